[rtl/ipd_pkg.sv]
// ipd_pkg: shared constants, codes and types of the image pooling downsampler
// no dependencies; used by ipd_scan, image_pooling_downsampler and the testbench
`default_nettype none

package ipd_pkg;

  // pixel format and sizes
  localparam int PIXEL_BITS   = 16;
  localparam int SUM_BITS     = PIXEL_BITS + 4;   // room for a 4x4 block sum
  localparam int MAX_SIDE     = 128;
  localparam int MIN_SIDE     = 4;
  localparam int CNT_BITS     = $clog2(MAX_SIDE);
  localparam int SIDE_BITS    = CNT_BITS + 1;
  localparam int BAND_DEPTH   = MAX_SIDE / 2;
  localparam int IDX_BITS     = $clog2(BAND_DEPTH);
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 8;

  localparam logic [SUM_BITS-1:0] ONE_VALUE = SUM_BITS'(1) << (PIXEL_BITS - 1);

  // pooling modes
  localparam logic [1:0] MODE_AVG2 = 2'd0;
  localparam logic [1:0] MODE_AVG4 = 2'd1;
  localparam logic [1:0] MODE_SUM4 = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_POOL_MODE  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_SIDE = CFG_IDX_BITS'(1);

  // position of one pixel inside the block grid
  typedef struct packed {
    logic [IDX_BITS-1:0] idx;        // block column
    logic                first_col;  // first pixel of a block row
    logic                last_col;   // last pixel of a block row
    logic                first_row;  // first row of a band
    logic                last_row;   // last row of a band
    logic                eoi;        // last pixel of the image
  } pos_t;

endpackage

`default_nettype wire

[rtl/ipd_scan.sv]
// ipd_scan: raster column/row counters and block position decode
// depends on ipd_pkg
`default_nettype none

module ipd_scan (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic                          restart,
  input  wire logic [1:0]                    pool_mode,
  input  wire logic [ipd_pkg::SIDE_BITS-1:0] image_side,
  output ipd_pkg::pos_t                      pos
);

  logic [ipd_pkg::CNT_BITS-1:0]  column;
  logic [ipd_pkg::CNT_BITS-1:0]  row;
  logic [ipd_pkg::CNT_BITS-1:0]  column_next;
  logic [ipd_pkg::CNT_BITS-1:0]  row_next;
  logic [ipd_pkg::CNT_BITS-1:0]  col;
  logic [ipd_pkg::CNT_BITS-1:0]  rw;
  logic [ipd_pkg::SIDE_BITS-1:0] side_clamp;
  logic [ipd_pkg::SIDE_BITS-1:0] side;
  logic [ipd_pkg::SIDE_BITS-1:0] col_inc;
  logic [ipd_pkg::SIDE_BITS-1:0] row_inc;
  logic                          blk4;

  // effective side: clamped, rounded down to the block size
  always_comb begin
    blk4 = (pool_mode != ipd_pkg::MODE_AVG2);
    if (image_side < ipd_pkg::SIDE_BITS'(ipd_pkg::MIN_SIDE)) begin
      side_clamp = ipd_pkg::SIDE_BITS'(ipd_pkg::MIN_SIDE);
    end else if (image_side > ipd_pkg::SIDE_BITS'(ipd_pkg::MAX_SIDE)) begin
      side_clamp = ipd_pkg::SIDE_BITS'(ipd_pkg::MAX_SIDE);
    end else begin
      side_clamp = image_side;
    end
    if (blk4) begin
      side = {side_clamp[ipd_pkg::SIDE_BITS-1:2], 2'b00};
    end else begin
      side = {side_clamp[ipd_pkg::SIDE_BITS-1:1], 1'b0};
    end
  end

  // position of the current pixel, restarting when out of the image
  always_comb begin
    if (({1'b0, column} >= side) || ({1'b0, row} >= side)) begin
      col = '0;
      rw  = '0;
    end else begin
      col = column;
      rw  = row;
    end
    if (blk4) begin
      pos.idx       = {1'b0, col[ipd_pkg::CNT_BITS-1:2]};
      pos.first_col = (col[1:0] == 2'b00);
      pos.last_col  = (col[1:0] == 2'b11);
      pos.first_row = (rw[1:0] == 2'b00);
      pos.last_row  = (rw[1:0] == 2'b11);
    end else begin
      pos.idx       = col[ipd_pkg::CNT_BITS-1:1];
      pos.first_col = !col[0];
      pos.last_col  = col[0];
      pos.first_row = !rw[0];
      pos.last_row  = rw[0];
    end
    pos.eoi = ({1'b0, col} == side - 1'b1) && ({1'b0, rw} == side - 1'b1);
  end

  // raster advance
  always_comb begin
    col_inc = {1'b0, col} + 1'b1;
    row_inc = {1'b0, rw} + 1'b1;
    if (col_inc >= side) begin
      column_next = '0;
      if (row_inc >= side) begin
        row_next = '0;
      end else begin
        row_next = row_inc[ipd_pkg::CNT_BITS-1:0];
      end
    end else begin
      column_next = col_inc[ipd_pkg::CNT_BITS-1:0];
      row_next    = rw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column <= '0;
      row    <= '0;
    end else if (step) begin
      column <= column_next;
      row    <= row_next;
    end
  end

endmodule

`default_nettype wire

[rtl/image_pooling_downsampler.sv]
// image_pooling_downsampler: streaming 2x2 / 4x4 average or clamped-sum pooling
// depends on ipd_pkg and ipd_scan
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, pixel_value           | in
//  output  | out_valid, out_ready, pooled_value,       | out
//          | end_of_image                              |
//  config  | cfg_write, cfg_index, cfg_data            | in
//
// one item per cycle while the sum stage does not hold; an item waits in the sum stage
// (line-store read issued at accept, add and write-back when the stage advances)
// and its result is loaded into the output register as it leaves the sum stage.
// synchronous reset clears counters, valids, pool_mode to 0 and image_side to 128.
// the sum stage holds only while it carries a result and the output register
// is full and not taken; items without a result never stall.
`default_nettype none

module image_pooling_downsampler (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [ipd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [ipd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ipd_pkg::PIXEL_BITS-1:0]    pixel_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [ipd_pkg::PIXEL_BITS-1:0]         pooled_value,
  output logic                                   end_of_image
);

  logic [1:0]                     pool_mode;
  logic [ipd_pkg::SIDE_BITS-1:0]  image_side;
  logic                           cfg_restart;
  logic                           accept;
  ipd_pkg::pos_t                  pos;
  logic [ipd_pkg::SUM_BITS-1:0]   horizontal_sum;
  logic [ipd_pkg::SUM_BITS-1:0]   horizontal_sum_next;
  logic                           s1_valid;
  ipd_pkg::pos_t                  s1_pos;
  logic [ipd_pkg::SUM_BITS-1:0]   band_rd;
  logic [ipd_pkg::SUM_BITS-1:0]   band_new;
  logic                           s1_result;
  logic                           s1_advance;
  logic [ipd_pkg::PIXEL_BITS-1:0] result;
  logic [ipd_pkg::SUM_BITS-1:0]   band_sums [ipd_pkg::BAND_DEPTH];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_mode  <= ipd_pkg::MODE_AVG2;
      image_side <= ipd_pkg::SIDE_BITS'(ipd_pkg::MAX_SIDE);
    end else if (cfg_write) begin
      if (cfg_index == ipd_pkg::REG_POOL_MODE) begin
        pool_mode <= cfg_data[1:0];
      end else if (cfg_index == ipd_pkg::REG_IMAGE_SIDE) begin
        image_side <= cfg_data;
      end
    end
  end

  // a write to a known register drops the image in progress
  always_comb begin
    cfg_restart = cfg_write &&
                  ((cfg_index == ipd_pkg::REG_POOL_MODE) ||
                   (cfg_index == ipd_pkg::REG_IMAGE_SIDE));
  end

  // raster position of the incoming item
  ipd_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .restart    (cfg_restart),
    .pool_mode  (pool_mode),
    .image_side (image_side),
    .pos        (pos)
  );

  // handshake
  always_comb begin
    s1_result  = s1_pos.last_col && s1_pos.last_row;
    s1_advance = s1_valid && (!s1_result || !out_valid || out_ready);
    in_ready   = !s1_valid || s1_advance;
    accept     = in_valid && in_ready;
  end

  // horizontal sum over the pixels of one block row
  always_comb begin
    if (pos.first_col) begin
      horizontal_sum_next = ipd_pkg::SUM_BITS'(pixel_value);
    end else begin
      horizontal_sum_next = horizontal_sum + ipd_pkg::SUM_BITS'(pixel_value);
    end
  end

  // sum stage registers and line-store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      horizontal_sum <= horizontal_sum_next;
      s1_pos         <= pos;
      band_rd        <= band_sums[pos.idx];
    end
  end

  // band column sum and pooled value
  always_comb begin
    if (s1_pos.first_row) begin
      band_new = horizontal_sum;
    end else begin
      band_new = band_rd + horizontal_sum;
    end
    case (pool_mode)
      ipd_pkg::MODE_AVG2: result = band_new[ipd_pkg::PIXEL_BITS+1:2];
      ipd_pkg::MODE_AVG4: result = band_new[ipd_pkg::PIXEL_BITS+3:4];
      default: begin
        if (band_new > ipd_pkg::ONE_VALUE) begin
          result = ipd_pkg::ONE_VALUE[ipd_pkg::PIXEL_BITS-1:0];
        end else begin
          result = band_new[ipd_pkg::PIXEL_BITS-1:0];
        end
      end
    endcase
  end

  // line-store write-back
  always_ff @(posedge clk) begin
    if (s1_advance && s1_pos.last_col) begin
      band_sums[s1_pos.idx] <= band_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_result) begin
      pooled_value <= result;
      end_of_image <= s1_pos.eoi;
    end
  end

  // a result leaving the sum stage lands in the output register
  assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_result) |=> out_valid)
    else $error("pooled item lost between sum stage and output");

  // a full output register that is not taken holds a result-bearing sum stage
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_result && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while sum stage is blocked");

  // a restarting configuration write puts the raster at the first block position
  assert property (@(posedge clk) disable iff (rst)
    cfg_restart |=> (pos.first_col && pos.first_row && (pos.idx == '0)))
    else $error("scan position not restarted after configuration write");

  // end of image only comes with the last column and last row of a block
  assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_pos.eoi) |-> (s1_pos.last_col && s1_pos.last_row))
    else $error("end of image outside a block corner");

endmodule

`default_nettype wire

[tb/testbench.sv]
// testbench: self-checking bench for image_pooling_downsampler (2x2 / 4x4 pooling)
// needs ipd_pkg and the block; predicts every pooled pixel and compares field by field
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned LAT_CYCLES   = 4;     // accept to output register, with margin
  localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int unsigned RANDOM_ITEMS = 150;
  localparam int unsigned BAND_ENTRIES = ipd_pkg::MAX_SIDE / 2;

  // codes the package does not name
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [ipd_pkg::CFG_IDX_BITS-1:0] REG_SPARE_A = ipd_pkg::CFG_IDX_BITS'(2);
  localparam logic [ipd_pkg::CFG_IDX_BITS-1:0] REG_SPARE_B = ipd_pkg::CFG_IDX_BITS'(3);

  typedef enum int {PIX_FULL, PIX_SMALL, PIX_TINY, PIX_EXTREME, PIX_FIXED} pix_kind_e;

  typedef struct packed {
    logic [ipd_pkg::PIXEL_BITS-1:0] value;
    logic                           eoi;
  } pooled_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_write = 1'b0;
  logic [ipd_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [ipd_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [ipd_pkg::PIXEL_BITS-1:0]    pixel_value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [ipd_pkg::PIXEL_BITS-1:0]    pooled_value;
  logic                              end_of_image;

  image_pooling_downsampler u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_value  (pixel_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pooled_value (pooled_value),
    .end_of_image (end_of_image)
  );

  // shadow registers and scan state of the pooling predictor
  logic [1:0]                   pool_mode_r = ipd_pkg::MODE_AVG2;
  logic [7:0]                   image_side_r = 8'd128;
  int unsigned                  col_pos = 0;
  int unsigned                  row_pos = 0;
  logic [ipd_pkg::SUM_BITS-1:0] row_sum = '0;
  logic [ipd_pkg::SUM_BITS-1:0] band_sum [BAND_ENTRIES];

  pooled_t     pending_pools[$];
  int unsigned error_count = 0;
  int unsigned pixels_sent = 0;
  bit          idle_on = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned block_of(logic [1:0] m);
    return (m == ipd_pkg::MODE_AVG2) ? 2 : 4;
  endfunction

  // side after clamping and rounding down to whole blocks
  function automatic int unsigned side_of(logic [1:0] m, logic [7:0] sv);
    int unsigned s;
    s = sv;
    if (s < ipd_pkg::MIN_SIDE) s = ipd_pkg::MIN_SIDE;
    if (s > ipd_pkg::MAX_SIDE) s = ipd_pkg::MAX_SIDE;
    return s - (s % block_of(m));
  endfunction

  function automatic void restart_scan();
    col_pos = 0;
    row_pos = 0;
    row_sum = '0;
  endfunction

  function automatic void shadow_write(logic [ipd_pkg::CFG_IDX_BITS-1:0] idx,
                                       logic [ipd_pkg::CFG_DATA_BITS-1:0] data);
    case (idx)
      ipd_pkg::REG_POOL_MODE: begin
        pool_mode_r = data[1:0];
        restart_scan();
      end
      ipd_pkg::REG_IMAGE_SIDE: begin
        image_side_r = data;
        restart_scan();
      end
      default: ;
    endcase
  endfunction

  // advance the scan by one pixel and queue the pooled pixel it completes
  function automatic void pool_predict(logic [ipd_pkg::PIXEL_BITS-1:0] px);
    int unsigned                  p;
    int unsigned                  s;
    int unsigned                  bi;
    logic [ipd_pkg::SUM_BITS-1:0] total;
    pooled_t                      r;
    p = block_of(pool_mode_r);
    s = side_of(pool_mode_r, image_side_r);
    if (col_pos >= s || row_pos >= s) restart_scan();
    if (col_pos % p == 0) row_sum = ipd_pkg::SUM_BITS'(px);
    else row_sum = row_sum + ipd_pkg::SUM_BITS'(px);
    if (col_pos % p == p - 1) begin
      bi = (col_pos / p) % BAND_ENTRIES;
      if (row_pos % p == 0) band_sum[bi] = row_sum;
      else band_sum[bi] = band_sum[bi] + row_sum;
      if (row_pos % p == p - 1) begin
        total = band_sum[bi];
        case (pool_mode_r)
          ipd_pkg::MODE_AVG2: r.value = ipd_pkg::PIXEL_BITS'(total >> 2);
          ipd_pkg::MODE_AVG4: r.value = ipd_pkg::PIXEL_BITS'(total >> 4);
          default: begin
            if (total > ipd_pkg::ONE_VALUE)
              r.value = ipd_pkg::ONE_VALUE[ipd_pkg::PIXEL_BITS-1:0];
            else
              r.value = total[ipd_pkg::PIXEL_BITS-1:0];
          end
        endcase
        r.eoi = (row_pos == s - 1) && (col_pos == s - 1);
        pending_pools.push_back(r);
      end
    end
    col_pos++;
    if (col_pos >= s) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= s) row_pos = 0;
    end
  endfunction

  function automatic logic [ipd_pkg::PIXEL_BITS-1:0] pick_pixel(
      pix_kind_e kind, logic [ipd_pkg::PIXEL_BITS-1:0] fixed);
    case (kind)
      PIX_SMALL:   return ipd_pkg::PIXEL_BITS'($urandom_range(0, 4095));
      PIX_TINY:    return ipd_pkg::PIXEL_BITS'($urandom_range(0, 2047));
      PIX_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
      PIX_FIXED:   return fixed;
      default:     return ipd_pkg::PIXEL_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  // one item on the pixel channel; called and returns at a falling edge
  task automatic send_pixel(logic [ipd_pkg::PIXEL_BITS-1:0] px);
    while (idle_on && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= px;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    pool_predict(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_pixels(int unsigned n, pix_kind_e kind,
                             logic [ipd_pkg::PIXEL_BITS-1:0] fixed = '0);
    repeat (n) send_pixel(pick_pixel(kind, fixed));
  endtask

  // stop sending and wait until every pooled pixel is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pools.size() != 0) @(negedge clk);
    repeat (LAT_CYCLES) @(negedge clk);
  endtask

  // one register write; the enable drops before the next write can start
  task automatic write_reg(logic [ipd_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [ipd_pkg::CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    shadow_write(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [1:0] m, logic [7:0] sv);
    settle();
    write_reg(ipd_pkg::REG_POOL_MODE, ipd_pkg::CFG_DATA_BITS'(m));
    write_reg(ipd_pkg::REG_IMAGE_SIDE, sv);
  endtask

  // receiver: ready decided at the rising edge, driven at the falling edge
  initial begin
    bit ready_next;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = !(idle_on && $urandom_range(99) < 21);
      end
      @(negedge clk);
      out_ready <= ready_next;
    end
  end

  // compare each pooled pixel with the oldest prediction
  always @(posedge clk) begin
    pooled_t exp_pool;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_pools.size() == 0) begin
        $display("%0t: unexpected item, pooled_value %h end_of_image %b",
                 $time, pooled_value, end_of_image);
        error_count++;
      end else begin
        exp_pool = pending_pools.pop_front();
        if (pooled_value !== exp_pool.value) begin
          $display("%0t: pooled_value expected %h actual %h",
                   $time, exp_pool.value, pooled_value);
          error_count++;
        end
        if (end_of_image !== exp_pool.eoi) begin
          $display("%0t: end_of_image expected %b actual %b",
                   $time, exp_pool.eoi, end_of_image);
          error_count++;
        end
      end
    end
  end

  // reset values: 2x2 mean over a 128 wide image, first band only
  task automatic test_reset_defaults();
    send_pixels(128, PIX_FIXED, '1);
    send_pixels(64, PIX_EXTREME);
    send_pixels(64, PIX_FULL);
  endtask

  // every mode on the smallest image, with end of image flags
  task automatic test_modes();
    configure(ipd_pkg::MODE_AVG2, 8'd4);
    send_pixels(16, PIX_FULL);
    configure(ipd_pkg::MODE_AVG4, 8'd4);
    send_pixels(16, PIX_FIXED, '1);
    send_pixels(16, PIX_FULL);
    configure(ipd_pkg::MODE_SUM4, 8'd4);
    send_pixels(16, PIX_FIXED, 16'd2048);   // sum exactly at one
    send_pixels(16, PIX_FIXED, 16'd2049);   // just over one
    send_pixels(16, PIX_FIXED, '1);
    send_pixels(16, PIX_TINY);
    configure(MODE_UNUSED, 8'd4);
    send_pixels(16, PIX_SMALL);
  endtask

  // side clamped to the legal range and rounded down to whole blocks
  task automatic test_side_limits();
    configure(ipd_pkg::MODE_AVG4, 8'd0);
    send_pixels(16, PIX_FULL);
    configure(ipd_pkg::MODE_AVG2, 8'd3);
    send_pixels(16, PIX_FULL);
    configure(ipd_pkg::MODE_AVG4, 8'd7);
    send_pixels(32, PIX_FULL);
    configure(ipd_pkg::MODE_AVG2, 8'd7);
    send_pixels(36, PIX_FULL);
    configure(ipd_pkg::MODE_AVG2, 8'd255);
    send_pixels(2 * 128, PIX_FULL);
  endtask

  // a register write drops the image in progress; a spare index does not
  task automatic test_restart_and_spare();
    configure(ipd_pkg::MODE_AVG2, 8'd8);
    send_pixels(10, PIX_FULL);
    settle();
    write_reg(ipd_pkg::REG_IMAGE_SIDE, 8'd8);
    send_pixels(64, PIX_FULL);
    configure(ipd_pkg::MODE_AVG2, 8'd4);
    send_pixels(6, PIX_FULL);
    settle();
    write_reg(REG_SPARE_A, 8'hA5);
    write_reg(REG_SPARE_B, 8'h5A);
    send_pixels(10, PIX_FULL);
  endtask

  // output held off while pixels keep coming, then a pause with results drained
  task automatic test_backpressure();
    configure(ipd_pkg::MODE_AVG2, 8'd8);
    hold_request = 1'b1;
    send_pixels(64, PIX_FULL);
    configure(ipd_pkg::MODE_AVG4, 8'd12);
    send_pixels(70, PIX_FULL);
    settle();
    send_pixels(74, PIX_FULL);
  endtask

  // no idling on either side for a long stretch
  task automatic test_back_to_back();
    configure(ipd_pkg::MODE_AVG4, 8'd8);
    idle_on = 1'b0;
    send_pixels(2 * 64, PIX_FULL);
    configure(ipd_pkg::MODE_AVG2, 8'd6);
    send_pixels(2 * 36, PIX_FULL);
    idle_on = 1'b1;
  endtask

  // random phases: mostly whole images, some cut short, some large sides
  task automatic test_random_phases();
    int unsigned start_count;
    int unsigned pick;
    int unsigned s;
    int unsigned p;
    int unsigned n;
    int unsigned left;
    logic [1:0]  m;
    logic [7:0]  sv;
    pix_kind_e   kind;
    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_ITEMS) begin
      m    = 2'($urandom_range(0, 3));
      pick = $urandom_range(99);
      if (pick < 85) sv = 8'($urandom_range(0, 20));
      else if (pick < 95) sv = 8'($urandom_range(21, 64));
      else sv = 8'($urandom_range(65, 255));
      pick = $urandom_range(0, 4);
      if (pick != 4) begin
        settle();
        if (pick != 1) write_reg(ipd_pkg::REG_POOL_MODE, ipd_pkg::CFG_DATA_BITS'(m));
        if (pick != 0) write_reg(ipd_pkg::REG_IMAGE_SIDE, sv);
        if ($urandom_range(0, 9) == 0)
          write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                    ipd_pkg::CFG_DATA_BITS'($urandom_range(0, 255)));
      end
      p = block_of(pool_mode_r);
      s = side_of(pool_mode_r, image_side_r);
      if (s <= 16) n = $urandom_range(1, 3) * s * s;
      else n = $urandom_range(1, 2) * p * s;
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, s * p);
      left = RANDOM_ITEMS - (pixels_sent - start_count);
      if (n > left) n = left;
      pick = $urandom_range(0, 9);
      if (pick < 5) kind = PIX_FULL;
      else if (pick < 7) kind = PIX_SMALL;
      else if (pick < 9) kind = PIX_TINY;
      else kind = PIX_EXTREME;
      send_pixels(n, kind);
    end
  endtask

  // test sequence
  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_modes();
    test_side_limits();
    test_restart_and_spare();
    test_backpressure();
    test_back_to_back();
    test_random_phases();
    settle();
    repeat (4 * LAT_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ipd_pkg.sv
rtl/ipd_scan.sv
rtl/image_pooling_downsampler.sv
tb/testbench.sv
